[design/assert_macros.svh]
// Assertion helpers shared by the RTL. All checks sample on the rising edge
// of clk and are switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/erlb_pkg.sv]
package erlb_pkg;

  localparam int unsigned MS_W = 32;

  typedef logic [MS_W-1:0] ms_t;
  typedef logic            cmd_t;

  localparam cmd_t CMD_CHECK = 1'b0;
  localparam cmd_t CMD_RESET = 1'b1;

  // The violation threshold is min_distance divided by four.
  localparam int unsigned THRESHOLD_SHIFT = 2;

  localparam ms_t MIN_DISTANCE_RESET = ms_t'(1000);

endpackage

[design/erlb_in_if.sv]
interface erlb_in_if;
  import erlb_pkg::*;

  logic valid;
  logic ready;
  cmd_t command;
  ms_t  now_ms;

  modport source (output valid, output command, output now_ms, input ready);
  modport sink (input valid, input command, input now_ms, output ready);
endinterface

[design/erlb_out_if.sv]
interface erlb_out_if;
  import erlb_pkg::*;

  logic valid;
  logic ready;
  logic blocked;
  ms_t  time_remaining;
  ms_t  backoff_ms;

  modport source (output valid, output blocked, output time_remaining, output backoff_ms,
                  input ready);
  modport sink (input valid, input blocked, input time_remaining, input backoff_ms,
                output ready);
endinterface

[design/event_rate_limiter_backoff_unit.sv]
// An item passes the input, update and result registers in order before its result is on out_ch.
// Throughput: one item per cycle while out_ch accepts; the limiter state updates once per item.
// Back-pressure from out_ch stalls the stages; each stage still fills while downstream is busy.
// Reset (rst_n low at a clock edge, synchronous) empties the pipeline, clears the limiter
// state and sets min_distance to 1000.
`include "assert_macros.svh"

module event_rate_limiter_backoff_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  erlb_pkg::ms_t      cfg_wdata,
  erlb_in_if.sink            in_ch,
  erlb_out_if.source         out_ch
);
  import erlb_pkg::*;

  // Configuration.
  ms_t  min_dist_r;

  // Input stage; now + min_distance is summed on capture.
  logic s1_v_r;
  cmd_t s1_cmd_r;
  ms_t  s1_now_r;
  ms_t  s1_npm_r;

  // Limiter state.
  ms_t  nat_r, nat_nxt;
  ms_t  extra_r, extra_nxt;
  ms_t  vcount_r, vcount_nxt;

  // Update stage results.
  logic s2_v_r;
  logic s2_blocked_r, blocked_nxt;
  ms_t  s2_nat_r;
  ms_t  s2_now_r;
  ms_t  s2_extra_r;

  // Result stage.
  logic out_v_r;
  logic out_blocked_r;
  ms_t  out_rem_r;
  ms_t  out_extra_r;

  logic out_free;
  logic s2_free;
  logic exec_go;
  logic in_go;
  logic allow;
  logic over;
  ms_t  threshold;
  ms_t  remaining;

  assign out_free = !out_v_r || out_ch.ready;
  assign s2_free  = !s2_v_r || out_free;
  assign exec_go  = s1_v_r && s2_free;
  assign in_ch.ready = !s1_v_r || s2_free;
  assign in_go    = in_ch.valid && in_ch.ready;

  assign threshold = min_dist_r >> THRESHOLD_SHIFT;
  assign allow     = (s1_now_r >= nat_r);
  assign over      = (vcount_r > threshold);

  always_comb begin
    nat_nxt     = nat_r;
    extra_nxt   = extra_r;
    vcount_nxt  = vcount_r;
    blocked_nxt = 1'b0;
    if (s1_cmd_r == CMD_RESET) begin
      nat_nxt    = '0;
      extra_nxt  = '0;
      vcount_nxt = '0;
    end else if (allow) begin
      if (over) begin
        extra_nxt  = extra_r + min_dist_r;
        vcount_nxt = '0;
      end else begin
        extra_nxt = '0;
      end
      nat_nxt = s1_npm_r + extra_nxt;
    end else begin
      vcount_nxt  = vcount_r + ms_t'(1);
      blocked_nxt = 1'b1;
    end
  end

  assign remaining = (s2_now_r >= s2_nat_r) ? '0 : (s2_nat_r - s2_now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DISTANCE_RESET;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      nat_r      <= '0;
      extra_r    <= '0;
      vcount_r   <= '0;
    end else begin
      if (cfg_we) begin
        min_dist_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (exec_go) begin
        nat_r    <= nat_nxt;
        extra_r  <= extra_nxt;
        vcount_r <= vcount_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_cmd_r <= in_ch.command;
      s1_now_r <= in_ch.now_ms;
      s1_npm_r <= in_ch.now_ms + min_dist_r;
    end
    if (exec_go) begin
      s2_blocked_r <= blocked_nxt;
      s2_nat_r     <= nat_nxt;
      s2_now_r     <= s1_now_r;
      s2_extra_r   <= extra_nxt;
    end
    if (out_free && s2_v_r) begin
      out_blocked_r <= s2_blocked_r;
      out_rem_r     <= remaining;
      out_extra_r   <= s2_extra_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.blocked        = out_blocked_r;
  assign out_ch.time_remaining = out_rem_r;
  assign out_ch.backoff_ms     = out_extra_r;

  // A blocked event leaves the next allowed time ahead of now, so time remains.
  `ASSERT_ALWAYS(a_blocked_has_wait, !(out_v_r && out_blocked_r) || (out_rem_r != '0),
                 "blocked result reports no remaining time")
  // An early check counts exactly one more violation.
  `ASSERT_NEXT(a_violation_count, exec_go && s1_cmd_r == CMD_CHECK && !allow,
               vcount_r == $past(vcount_r) + ms_t'(1), "violation count did not advance")
  // A reset command leaves the limiter state all clear.
  `ASSERT_NEXT(a_reset_clears, exec_go && s1_cmd_r == CMD_RESET,
               nat_r == '0 && extra_r == '0 && vcount_r == '0, "reset command left state")
  // The backoff published with an update matches the stored backoff.
  `ASSERT_NEXT(a_backoff_tracks, exec_go, s2_extra_r == extra_r,
               "published backoff differs from stored backoff")

endmodule

[bench/tb_event_rate_limiter_backoff_unit.sv]
module tb_event_rate_limiter_backoff_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import erlb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct {
    logic blocked;
    ms_t  time_remaining;
    ms_t  backoff_ms;
  } limiter_result_t;

  // Tracks the limiter state from accepted inputs and checks each result in order.
  class limiter_scoreboard;
    ms_t min_distance;
    ms_t next_allowed;
    ms_t extra_distance;
    ms_t violation_count;
    limiter_result_t pending_results[$];
    int unsigned mismatch_count;

    function new();
      min_distance = MIN_DISTANCE_RESET;
      next_allowed = '0;
      extra_distance = '0;
      violation_count = '0;
      mismatch_count = 0;
    endfunction

    function void set_min_distance(ms_t value);
      min_distance = value;
    endfunction

    function void note_input(cmd_t command, ms_t now_val);
      limiter_result_t res;
      ms_t threshold;
      threshold = min_distance >> THRESHOLD_SHIFT;
      res.blocked = 1'b0;
      if (command == CMD_RESET) begin
        next_allowed = '0;
        extra_distance = '0;
        violation_count = '0;
      end else if (now_val >= next_allowed) begin
        if (violation_count > threshold) begin
          extra_distance = extra_distance + min_distance;
          violation_count = '0;
        end else begin
          extra_distance = '0;
        end
        next_allowed = now_val + min_distance + extra_distance;
      end else begin
        violation_count = violation_count + 1;
        res.blocked = 1'b1;
      end
      res.time_remaining = (now_val >= next_allowed) ? '0 : next_allowed - now_val;
      res.backoff_ms = extra_distance;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic blocked, ms_t time_remaining, ms_t backoff_ms);
      limiter_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: blocked %0d time_remaining %0d backoff_ms %0d",
               blocked, time_remaining, backoff_ms);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (blocked !== want.blocked) begin
        $error("blocked: expected %0d, got %0d", want.blocked, blocked);
        mismatch_count++;
      end
      if (time_remaining !== want.time_remaining) begin
        $error("time_remaining: expected %0d, got %0d", want.time_remaining, time_remaining);
        mismatch_count++;
      end
      if (backoff_ms !== want.backoff_ms) begin
        $error("backoff_ms: expected %0d, got %0d", want.backoff_ms, backoff_ms);
        mismatch_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  ms_t  cfg_wdata;

  erlb_in_if  in_ch();
  erlb_out_if out_ch();

  limiter_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned holdoff_left;
  bit          holdoff_req;
  int unsigned cycle_count;
  ms_t         sim_ms;

  event_rate_limiter_backoff_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver stalls at random; a requested hold-off keeps ready low for a long stretch.
  always @(posedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.blocked, out_ch.time_remaining, out_ch.backoff_ms);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Valid stays high from one transfer to the next unless an idle gap is drawn.
  task automatic send_item(cmd_t command, ms_t now_val);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= command;
    in_ch.now_ms <= now_val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(command, now_val);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_min_distance(ms_t value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_min_distance(value);
  endtask

  // Most items follow a running clock so that bursts of early events build up backoff.
  task automatic run_phase(int unsigned n_items, int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned drain_at);
    int unsigned pick;
    longint unsigned window;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sim_ms = $urandom_range(1) ? ms_t'($urandom()) : 32'hFFFF_F000 + $urandom_range(4000);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == drain_at) begin
        wait_drained();
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(CMD_RESET, ms_t'($urandom()));
      end else if (pick < 8) begin
        sim_ms = $urandom();
        send_item(CMD_CHECK, sim_ms);
      end else if (pick < 16) begin
        sim_ms = sb.next_allowed - ms_t'($urandom_range(1));
        send_item(CMD_CHECK, sim_ms);
      end else begin
        window = longint'(sb.min_distance) + longint'(sb.extra_distance);
        if (window > 3000) begin
          window = 3000;
        end
        sim_ms = sim_ms + ms_t'($urandom_range(int'(window / 3) + 1));
        send_item(CMD_CHECK, sim_ms);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_CHECK;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_left = 0;
    holdoff_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default distance: allow, early block, exact hit, and a next time that wraps past zero.
    send_item(CMD_CHECK, 32'd0);
    send_item(CMD_CHECK, 32'd999);
    send_item(CMD_CHECK, 32'd1000);
    send_item(CMD_RESET, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 32'hFFFF_FFFF);
    send_item(CMD_CHECK, 32'd5);
    send_item(CMD_CHECK, 32'h8000_0000);

    // Zero distance: any counted violation grows the backoff by nothing.
    write_min_distance(32'd0);
    send_item(CMD_CHECK, 32'd10);
    send_item(CMD_CHECK, 32'd9);
    send_item(CMD_CHECK, 32'd10);

    // Distance four: two early events exceed the threshold and the backoff grows, then clears.
    write_min_distance(32'd4);
    send_item(CMD_CHECK, 32'd100);
    send_item(CMD_CHECK, 32'd101);
    send_item(CMD_CHECK, 32'd102);
    send_item(CMD_CHECK, 32'd104);
    send_item(CMD_CHECK, 32'd105);
    send_item(CMD_CHECK, 32'd112);
    send_item(CMD_RESET, 32'd0);

    write_min_distance(32'd8);
    run_phase(220, 0, 0, 0);
    write_min_distance(MIN_DISTANCE_RESET);
    run_phase(200, 78, 0, 0);
    write_min_distance(32'd0);
    run_phase(200, 0, 78, 0);
    write_min_distance(32'd20);
    run_phase(200, 31, 31, 0);

    // The receiver holds off while items keep coming, so the input side must stall.
    write_min_distance(32'hFFFF_FFFF);
    holdoff_req = 1'b1;
    run_phase(150, 0, 0, 0);

    write_min_distance(32'd3);
    run_phase(200, 0, 0, 100);
    write_min_distance(ms_t'($urandom_range(64, 4)));
    run_phase(200, 31, 31, 0);
    write_min_distance(ms_t'($urandom()));
    run_phase(263, 0, 78, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[event_rate_limiter_backoff_unit.f]
+incdir+design
design/erlb_pkg.sv
design/erlb_in_if.sv
design/erlb_out_if.sv
design/event_rate_limiter_backoff_unit.sv
bench/tb_event_rate_limiter_backoff_unit.sv
